[design/sorted_unique_set_insert_macros.svh]
// Assertion macros for the sorted set block.
`ifndef SORTED_UNIQUE_SET_INSERT_MACROS_SVH
`define SORTED_UNIQUE_SET_INSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SSI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SSI_ASSERT_SAME(label, ante, cons)
`define SSI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/ssi_pkg.sv]
`timescale 1ns / 1ps
package ssi_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 31;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int MAX_OUT  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LIST   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_LIST_ITEM  = 3'd3,
    ST_LIST_EMPTY = 3'd4,
    ST_CLEARED    = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert;
    logic               rotate;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

[design/ssi_request_if.sv]
`timescale 1ns / 1ps
interface ssi_request_if
  import ssi_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

[design/ssi_response_if.sv]
`timescale 1ns / 1ps
interface ssi_response_if
  import ssi_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  item_value;
  logic [POS_W-1:0]    position;
  logic                last;

  modport source (output valid, output status, output item_value, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input item_value, input position,
                  input last, output ready);
endinterface

[design/ssi_cell.sv]
`timescale 1ns / 1ps
module ssi_cell
  import ssi_pkg::*;
  (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               occupied,
  input  logic               left_lt,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [VALUE_W-1:0] right_value,
  output logic [VALUE_W-1:0] value,
  output logic               lt,
  output logic               eq
);

  assign lt = occupied && (value < ctrl.value);
  assign eq = occupied && (value == ctrl.value);

  // Insert: the first cell not below the new value takes it, cells above shift up.
  // Rotate: every occupied cell takes its right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.insert && !lt) begin
      value <= left_lt ? ctrl.value : left_value;
    end else if (ctrl.rotate && occupied) begin
      value <= right_value;
    end
  end

endmodule

[design/sorted_unique_set_insert.sv]
`timescale 1ns / 1ps
// Insert and clear: result registered next cycle; one item a cycle while output is free.
// List: one result a cycle while the sink takes them; the chain rotates once per stored
// value, and stays busy until all have rotated (results beyond sixteen are not emitted).
// The result register lets the next beat be taken while the sink takes a held result.
// Reset (synchronous, active high) empties the set and drops any held result.
module sorted_unique_set_insert
  import ssi_pkg::*;
  (
  input  logic clk,
  input  logic rst,
  ssi_request_if.sink    request,
  ssi_response_if.source response
);

  `include "sorted_unique_set_insert_macros.svh"

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] step, step_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [POS_W-1:0]    out_pos;
  logic                out_last;

  cell_ctrl_t         ctrl;
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] lt, eq, hit, occupied;

  logic               slot_free, accept, dup, full, emitting, load;
  logic [POS_W-1:0]   hit_pos;
  status_t            load_status;
  logic [VALUE_W-1:0] load_value;
  logic [POS_W-1:0]   load_pos;
  logic               load_last;
  int                 emit_n;

  // Chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_lt;
    logic [VALUE_W-1:0] left_value;
    logic [VALUE_W-1:0] right_value;

    assign occupied[i] = CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = ctrl.value;
    end else begin : g_body
      assign left_lt    = lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_value = cell_value[0];
    end else begin : g_mid
      logic tail;
      assign tail        = (CNT_W'(i) + CNT_W'(1)) == count;
      assign right_value = tail ? cell_value[0] : cell_value[i+1];
    end

    assign hit[i] = left_lt && !lt[i];

    ssi_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupied[i]),
      .left_lt    (left_lt),
      .left_value (left_value),
      .right_value(right_value),
      .value      (cell_value[i]),
      .lt         (lt[i]),
      .eq         (eq[i])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) hit_pos = hit_pos | POS_W'(i);
    end
  end

  assign dup       = |eq;
  assign full      = count == CNT_W'(CAPACITY);
  assign slot_free = !out_valid || response.ready;
  assign accept    = request.valid && request.ready;
  assign emit_n    = (int'(count) < MAX_OUT) ? int'(count) : MAX_OUT;
  assign emitting  = int'(step) < MAX_OUT;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && op_t'(request.operation) == OP_LIST && count != '0) state_next = S_LIST;
      end
      S_LIST: begin
        if ((!emitting || slot_free) && (CNT_W'(step) + CNT_W'(1)) == count) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    request.ready = 1'b0;
    ctrl.insert   = 1'b0;
    ctrl.rotate   = 1'b0;
    ctrl.value    = request.value;
    count_next    = count;
    step_next     = step;
    load          = 1'b0;
    load_status   = ST_INSERTED;
    load_value    = request.value;
    load_pos      = '0;
    load_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        request.ready = slot_free;
        step_next     = '0;
        if (accept) begin
          unique case (op_t'(request.operation))
            OP_INSERT: begin
              load = 1'b1;
              if (dup) begin
                load_status = ST_DUPLICATE;
                load_pos    = hit_pos;
              end else if (full) begin
                load_status = ST_FULL;
              end else begin
                load_status = ST_INSERTED;
                load_pos    = hit_pos;
                ctrl.insert = 1'b1;
                count_next  = count + CNT_W'(1);
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                load        = 1'b1;
                load_status = ST_LIST_EMPTY;
                load_value  = '0;
              end
            end
            OP_CLEAR: begin
              load        = 1'b1;
              load_status = ST_CLEARED;
              load_value  = '0;
              count_next  = '0;
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        // Rotate once per stored value; emit only while under the result limit.
        if (!emitting || slot_free) begin
          ctrl.rotate = 1'b1;
          step_next   = step + IDX_W'(1);
          if (emitting) begin
            load        = 1'b1;
            load_status = ST_LIST_ITEM;
            load_value  = cell_value[0];
            load_pos    = POS_W'(step);
            load_last   = (int'(step) + 1) == emit_n;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= load_status;
      out_value  <= load_value;
      out_pos    <= load_pos;
      out_last   <= load_last;
    end
  end

  assign response.valid      = out_valid;
  assign response.status     = out_status;
  assign response.item_value = out_value;
  assign response.position   = out_pos;
  assign response.last       = out_last;

  `SSI_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `SSI_ASSERT_SAME(a_busy_no_ready, state == S_LIST, !request.ready)
  `SSI_ASSERT_SAME(a_hit_onehot, state == S_IDLE, $onehot0(hit))
  `SSI_ASSERT_NEXT(a_insert_grows, ctrl.insert, count == $past(count) + CNT_W'(1))
  `SSI_ASSERT_SAME(a_no_overwrite, out_valid && !response.ready, !load)

endmodule

[bench/sorted_unique_set_insert_test.sv]
`timescale 1ns / 1ps
module sorted_unique_set_insert_test;
  import ssi_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED    = 2'd3;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = {VALUE_W{1'b1}};
  localparam int                 CYCLE_LIMIT  = 200000;
  localparam int                 DRAIN_CYCLES = 40;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]   position;
    logic               last;
  } set_result_t;

  logic clk;
  logic rst;

  ssi_request_if  req_if ();
  ssi_response_if rsp_if ();

  sorted_unique_set_insert dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if),
    .response (rsp_if)
  );

  // Shadow of the set: ascending values and how many are held.
  logic [VALUE_W-1:0] set_values [CAPACITY];
  int                 set_count;
  set_result_t        pending_results [$];
  set_result_t        want;
  int                 error_count;
  int                 cycle_count;
  bit                 no_idle;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 8);
  endfunction

  function automatic void push_result(status_t status, logic [VALUE_W-1:0] item_value,
                                      int position, logic last);
    set_result_t res;
    res.status     = status;
    res.item_value = item_value;
    res.position   = POS_W'(position);
    res.last       = last;
    pending_results.push_back(res);
  endfunction

  function automatic void predict_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
    int slot;
    int i;
    slot = 0;
    if (op == OP_INSERT) begin
      while (slot < set_count && set_values[slot] < val) slot++;
      if (slot < set_count && set_values[slot] == val) begin
        push_result(ST_DUPLICATE, val, slot, 1'b1);
      end else if (set_count >= CAPACITY) begin
        push_result(ST_FULL, val, 0, 1'b1);
      end else begin
        // shift larger values up one slot
        for (i = set_count; i > slot; i--) set_values[i] = set_values[i - 1];
        set_values[slot] = val;
        set_count++;
        push_result(ST_INSERTED, val, slot, 1'b1);
      end
    end else if (op == OP_LIST) begin
      if (set_count == 0) begin
        push_result(ST_LIST_EMPTY, '0, 0, 1'b1);
      end else begin
        for (i = 0; i < set_count && i < MAX_OUT; i++)
          push_result(ST_LIST_ITEM, set_values[i], i,
                      (i + 1 == set_count || i + 1 == MAX_OUT));
      end
    end else if (op == OP_CLEAR) begin
      set_count = 0;
      push_result(ST_CLEARED, '0, 0, 1'b1);
    end
    // unused code: drop, no result
  endfunction

  function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
    end
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
    while (idle_now()) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_request(op, val);
  endtask

  task automatic test_empty_set();
    send_request(OP_LIST, VALUE_W'($urandom));
    send_request(OP_CLEAR, VALUE_W'($urandom));
  endtask

  task automatic test_extremes();
    send_request(OP_INSERT, VALUE_MAX);
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, VALUE_MAX);
    send_request(OP_UNUSED, VALUE_W'($urandom));
  endtask

  task automatic test_capacity();
    while (set_count < CAPACITY) send_request(OP_INSERT, VALUE_W'($urandom));
    send_request(OP_INSERT, VALUE_W'($urandom));
    // duplicate wins over full
    send_request(OP_INSERT, set_values[$urandom_range(0, CAPACITY - 1)]);
    send_request(OP_LIST, VALUE_W'($urandom));
    send_request(OP_CLEAR, VALUE_W'($urandom));
    send_request(OP_LIST, VALUE_W'($urandom));
  endtask

  task automatic test_random_traffic(input int item_total);
    int                 sent;
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] val;
    sent = 0;
    while (sent < item_total) begin
      no_idle = (sent >= 100 && sent < 160);
      pick    = $urandom_range(0, 99);
      val     = VALUE_W'($urandom);
      if (pick < 70) begin
        op = OP_INSERT;
        case ($urandom_range(0, 2))
          1: begin
            val = VALUE_W'($urandom_range(0, 63));
          end
          2: begin
            if (set_count > 0) val = set_values[$urandom_range(0, set_count - 1)];
          end
          default: begin
          end
        endcase
      end else if (pick < 90) begin
        op = OP_LIST;
      end else if (pick < 95) begin
        op = OP_CLEAR;
      end else begin
        op = OP_UNUSED;
      end
      send_request(op, val);
      if (op != OP_UNUSED) sent++;
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= !idle_now();
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual status %0d value %0d pos %0d",
                 $time, rsp_if.status, rsp_if.item_value, rsp_if.position);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, rsp_if.status);
        check_field("item_value", want.item_value, rsp_if.item_value);
        check_field("position", want.position, rsp_if.position);
        check_field("last", want.last, rsp_if.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_unique_set_insert verification failed");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.operation = OP_INSERT;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
    set_count        = 0;
    error_count      = 0;
    cycle_count      = 0;
    no_idle          = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_set();
    test_extremes();
    test_capacity();
    test_random_traffic(232);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_unique_set_insert verification clean");
    end else begin
      $display("sorted_unique_set_insert verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/ssi_pkg.sv
design/ssi_request_if.sv
design/ssi_response_if.sv
design/ssi_cell.sv
design/sorted_unique_set_insert.sv
bench/sorted_unique_set_insert_test.sv
